[rtl/g2l_pkg.sv]
package g2l_pkg;

  // Span of the lunar year table
  localparam int FIRST_YEAR = 1900;
  localparam int LAST_YEAR  = 2100;
  localparam int ROM_WORDS  = 201;

  // Year word layout
  localparam int WORD_W   = 17;
  localparam int YLEN_W   = 9;
  localparam int MLEN_W   = 5;
  localparam int MONTHS   = 12;
  localparam int BASE_LEN = 348;

  // Day count widths
  localparam int DAYS_W = 21;
  localparam int DIFF_W = 23;

  // Day count of lunar new year of FIRST_YEAR (31 January) in the shifted civil
  // scale; BIAS adds the one that the day-of-year term leaves in the sum.
  localparam int EPOCH_YP       = FIRST_YEAR + 399;
  localparam int NEWYEAR_DAYNUM = 365 * EPOCH_YP + EPOCH_YP / 4 - EPOCH_YP / 100
                                  + EPOCH_YP / 400 + 306 + 31 - 1;
  localparam int EPOCH_BIAS     = NEWYEAR_DAYNUM + 1;

  // Reciprocal of 25 for dividends up to 2047
  localparam int RECIP25       = 1311;
  localparam int RECIP25_SHIFT = 15;

  typedef struct packed {
    logic              done;
    logic              neg;
    logic [DAYS_W-1:0] days;
  } g2l_day_t;

  localparam logic [WORD_W-1:0] YEAR_ROM [0:ROM_WORDS-1] = '{
    17'h04bd8,17'h04ae0,17'h0a570,17'h054d5,17'h0d260,17'h0d950,17'h16554,17'h056a0,
    17'h09ad0,17'h055d2,17'h04ae0,17'h0a5b6,17'h0a4d0,17'h0d250,17'h1d255,17'h0b540,
    17'h0d6a0,17'h0ada2,17'h095b0,17'h14977,17'h04970,17'h0a4b0,17'h0b4b5,17'h06a50,
    17'h06d40,17'h1ab54,17'h02b60,17'h09570,17'h052f2,17'h04970,17'h06566,17'h0d4a0,
    17'h0ea50,17'h06e95,17'h05ad0,17'h02b60,17'h186e3,17'h092e0,17'h1c8d7,17'h0c950,
    17'h0d4a0,17'h1d8a6,17'h0b550,17'h056a0,17'h1a5b4,17'h025d0,17'h092d0,17'h0d2b2,
    17'h0a950,17'h0b557,17'h06ca0,17'h0b550,17'h15355,17'h04da0,17'h0a5b0,17'h14573,
    17'h052b0,17'h0a9a8,17'h0e950,17'h06aa0,17'h0aea6,17'h0ab50,17'h04b60,17'h0aae4,
    17'h0a570,17'h05260,17'h0f263,17'h0d950,17'h05b57,17'h056a0,17'h096d0,17'h04dd5,
    17'h04ad0,17'h0a4d0,17'h0d4d4,17'h0d250,17'h0d558,17'h0b540,17'h0b6a0,17'h195a6,
    17'h095b0,17'h049b0,17'h0a974,17'h0a4b0,17'h0b27a,17'h06a50,17'h06d40,17'h0af46,
    17'h0ab60,17'h09570,17'h04af5,17'h04970,17'h064b0,17'h074a3,17'h0ea50,17'h06b58,
    17'h055c0,17'h0ab60,17'h096d5,17'h092e0,17'h0c960,17'h0d954,17'h0d4a0,17'h0da50,
    17'h07552,17'h056a0,17'h0abb7,17'h025d0,17'h092d0,17'h0cab5,17'h0a950,17'h0b4a0,
    17'h0baa4,17'h0ad50,17'h055d9,17'h04ba0,17'h0a5b0,17'h15176,17'h052b0,17'h0a930,
    17'h07954,17'h06aa0,17'h0ad50,17'h05b52,17'h04b60,17'h0a6e6,17'h0a4e0,17'h0d260,
    17'h0ea65,17'h0d530,17'h05aa0,17'h076a3,17'h096d0,17'h04afb,17'h04ad0,17'h0a4d0,
    17'h1d0b6,17'h0d250,17'h0d520,17'h0dd45,17'h0b5a0,17'h056d0,17'h055b2,17'h049b0,
    17'h0a577,17'h0a4b0,17'h0aa50,17'h1b255,17'h06d20,17'h0ada0,17'h14b63,17'h09370,
    17'h049f8,17'h04970,17'h064b0,17'h168a6,17'h0ea50,17'h06b20,17'h1a6c4,17'h0aae0,
    17'h092e0,17'h0d2e3,17'h0c960,17'h0d557,17'h0d4a0,17'h0da50,17'h05d55,17'h056a0,
    17'h0a6d0,17'h055d4,17'h052d0,17'h0a9b8,17'h0a950,17'h0b4a0,17'h0b6a6,17'h0ad50,
    17'h055a0,17'h0aba4,17'h0a5b0,17'h052b0,17'h0b273,17'h06930,17'h07337,17'h06aa0,
    17'h0ad50,17'h14b55,17'h04b60,17'h0a570,17'h054e4,17'h0d160,17'h0e968,17'h0d520,
    17'h0daa0,17'h16aa6,17'h056d0,17'h04ae0,17'h0a9d4,17'h0a2d0,17'h0d150,17'h0f252,
    17'h0d520
  };

  function automatic logic [WORD_W-1:0] year_word(input logic [7:0] idx);
    if (idx < 8'(ROM_WORDS)) begin
      return YEAR_ROM[idx];
    end
    return '0;
  endfunction

  // Days from 1 March to the first of the month, March-based year
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] b;
    case (m)
      4'd3:    b = 9'd0;
      4'd4:    b = 9'd31;
      4'd5:    b = 9'd61;
      4'd6:    b = 9'd92;
      4'd7:    b = 9'd122;
      4'd8:    b = 9'd153;
      4'd9:    b = 9'd184;
      4'd10:   b = 9'd214;
      4'd11:   b = 9'd245;
      4'd12:   b = 9'd275;
      4'd1:    b = 9'd306;
      4'd2:    b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  function automatic logic [MLEN_W-1:0] leap_len(input logic [WORD_W-1:0] w);
    if (w[3:0] == 4'd0) begin
      return '0;
    end
    return w[16] ? MLEN_W'(30) : MLEN_W'(29);
  endfunction

  function automatic logic [MLEN_W-1:0] month_len(input logic [WORD_W-1:0] w,
                                                  input logic [3:0] m);
    logic [4:0] b;
    b = 5'd16 - 5'(m);
    return w[b] ? MLEN_W'(30) : MLEN_W'(29);
  endfunction

  function automatic logic [YLEN_W-1:0] year_len(input logic [WORD_W-1:0] w);
    return YLEN_W'(BASE_LEN) + YLEN_W'($countones(w[15:4])) + YLEN_W'(leap_len(w));
  endfunction

endpackage

[rtl/g2l_ram.sv]
module g2l_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 201
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/g2l_daycount.sv]
// Day distance from lunar new year of the first table year, three stages.
module g2l_daycount (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [11:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  output g2l_pkg::g2l_day_t  res
);

  // stage 1: shifted year and day within the March-based year
  logic        s1_valid;
  logic [12:0] s1_yp;
  logic [8:0]  s1_doy;

  // stage 2: leap year terms
  logic                       s2_valid;
  logic [20:0]                s2_y365;
  logic [10:0]                s2_q4;
  logic [6:0]                 s2_q100;
  logic [8:0]                 s2_doy;
  logic [21:0]                q_prod;
  logic [21:0]                total;
  logic [g2l_pkg::DIFF_W-1:0] diff;

  assign q_prod = 22'(s1_yp[12:2]) * 22'(g2l_pkg::RECIP25);
  assign total  = 22'(s2_y365) + 22'(s2_q4) - 22'(s2_q100) + 22'(s2_q100[6:2])
                  + 22'(s2_doy);
  assign diff   = {1'b0, total} - g2l_pkg::DIFF_W'(g2l_pkg::EPOCH_BIAS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      res.done <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      res.done <= s2_valid;
    end
    s1_yp    <= 13'(year) + 13'd400 - ((month <= 4'd2) ? 13'd1 : 13'd0);
    s1_doy   <= g2l_pkg::month_base(month) + 9'(day);
    s2_y365  <= 21'(s1_yp) * 21'd365;
    s2_q4    <= s1_yp[12:2];
    s2_q100  <= q_prod[g2l_pkg::RECIP25_SHIFT +: 7];
    s2_doy   <= s1_doy;
    res.neg  <= diff[g2l_pkg::DIFF_W-1];
    res.days <= diff[g2l_pkg::DAYS_W-1:0];
  end

endmodule

[rtl/gregorian_to_lunar_date_unit.sv]
// Steps: the day count, one lunar year walked a cycle (up to the table depth),
// the month steps, then the output register. One word is in flight.
// The next word is taken in the idle state after the result loads, later if the
// output register still holds an untaken word. The year walk sets throughput.
// Reset: control clears; the table memory is then loaded one year word a cycle
// (all depth words, 201 by default) with in_ready low.
module gregorian_to_lunar_date_unit #(
  parameter int LAST_YEAR = g2l_pkg::LAST_YEAR
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] greg_year,
  input  logic [3:0]  greg_month,
  input  logic [4:0]  greg_day,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [11:0] lunar_year,
  output logic [3:0]  lunar_month,
  output logic [4:0]  lunar_day,
  output logic        is_leap_month
);

  localparam int DEPTH = LAST_YEAR - g2l_pkg::FIRST_YEAR + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // One-hot controller states
  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,  // load the year table
    S_IDLE  = 6'b000010,  // wait for a word
    S_PREP  = 6'b000100,  // day count in flight
    S_YEAR  = 6'b001000,  // take off whole lunar years
    S_MONTH = 6'b010000,  // take off months, leap month after its base
    S_DONE  = 6'b100000   // hand the result to the output register
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
  } res_t;

  state_t                        state, state_next;
  logic [IDX_W-1:0]              idx, idx_next;
  logic [g2l_pkg::DAYS_W-1:0]    off, off_next;
  logic [3:0]                    mon, mon_next;
  logic                          in_leap, in_leap_next;
  logic [g2l_pkg::WORD_W-1:0]    word, word_next;
  res_t                          res, res_next;

  logic                          ram_we;
  logic [g2l_pkg::WORD_W-1:0]    ram_rdata;
  logic [g2l_pkg::YLEN_W-1:0]    ylen;
  logic [g2l_pkg::MLEN_W-1:0]    mlen;
  logic                          month_ok;
  logic                          accept;
  logic                          out_load;
  g2l_pkg::g2l_day_t             day_res;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign month_ok = (greg_month >= 4'd1) && (greg_month <= 4'(g2l_pkg::MONTHS));
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // Year table: written during the load sweep, read one year ahead of the walk.
  // The read address is the next walk index, so the data lines up with idx.
  g2l_ram #(
    .WIDTH (g2l_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_year_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (g2l_pkg::year_word(8'(idx))),
    .raddr (idx_next),
    .rdata (ram_rdata)
  );

  // Only dates with a real month start the day count, so a stale done pulse
  // never meets a later word.
  g2l_daycount u_daycount (
    .clk   (clk),
    .rst   (rst),
    .start (accept && month_ok),
    .year  (greg_year),
    .month (greg_month),
    .day   (greg_day),
    .res   (day_res)
  );

  assign ylen = g2l_pkg::year_len(ram_rdata);
  assign mlen = in_leap ? g2l_pkg::leap_len(word) : g2l_pkg::month_len(word, mon);

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    off_next     = off;
    mon_next     = mon;
    in_leap_next = in_leap;
    word_next    = word;
    res_next     = res;
    ram_we       = 1'b0;
    case (state)
      S_INIT: begin
        ram_we = 1'b1;
        if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (month_ok) begin
            state_next = S_PREP;
          end else begin
            // month code out of range: empty result
            res_next   = '0;
            state_next = S_DONE;
          end
        end
      end
      S_PREP: begin
        if (day_res.done) begin
          if (day_res.neg) begin
            // before lunar new year of the first table year
            res_next   = '0;
            state_next = S_DONE;
          end else begin
            off_next   = day_res.days;
            idx_next   = '0;
            state_next = S_YEAR;
          end
        end
      end
      S_YEAR: begin
        if (off < g2l_pkg::DAYS_W'(ylen)) begin
          word_next    = ram_rdata;
          mon_next     = 4'd1;
          in_leap_next = 1'b0;
          state_next   = S_MONTH;
        end else begin
          off_next = off - g2l_pkg::DAYS_W'(ylen);
          if (idx == LAST_IDX) begin
            // past the end of the last table year
            res_next   = '0;
            state_next = S_DONE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      S_MONTH: begin
        if (off < g2l_pkg::DAYS_W'(mlen)) begin
          res_next.valid = 1'b1;
          res_next.year  = 12'(g2l_pkg::FIRST_YEAR) + 12'(idx);
          res_next.month = mon;
          res_next.day   = 5'(off) + 5'd1;
          res_next.leap  = in_leap;
          state_next     = S_DONE;
        end else begin
          off_next = off - g2l_pkg::DAYS_W'(mlen);
          if (!in_leap && (mon == word[3:0])) begin
            // leap month follows its base month
            in_leap_next = 1'b1;
          end else if (mon == 4'(g2l_pkg::MONTHS)) begin
            res_next   = '0;
            state_next = S_DONE;
          end else begin
            in_leap_next = 1'b0;
            mon_next     = mon + 4'd1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
    off     <= off_next;
    mon     <= mon_next;
    in_leap <= in_leap_next;
    word    <= word_next;
    res     <= res_next;
  end

  // Output register: holds the finished word while the walk goes idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      valid_res     <= res.valid;
      lunar_year    <= res.year;
      lunar_month   <= res.month;
      lunar_day     <= res.day;
      is_leap_month <= res.leap;
    end
  end

  // A word with no valid result carries no date.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |->
      (lunar_year == 12'd0 && lunar_month == 4'd0 && lunar_day == 5'd0 && !is_leap_month))
    else $error("invalid result carries a nonzero date");

  // A found date lies in a real month and day.
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && valid_res) |->
      (lunar_month >= 4'd1 && lunar_month <= 4'd12 && lunar_day >= 5'd1 &&
       lunar_day <= 5'd30))
    else $error("lunar month or day out of range");

  // The year walk never runs past the table.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_YEAR) |-> (idx <= LAST_IDX))
    else $error("year walk beyond table");

  // The month walk stays within the twelve months.
  a_month_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MONTH) |-> (mon >= 4'd1 && mon <= 4'd12))
    else $error("month walk out of range");

  // The day and valid flag of a result stalled on the output side hold while the walk works on.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(lunar_day) && $stable(valid_res)))
    else $error("stalled result changed");

endmodule
